>>> hw/rtl/sstg_pkg.sv
// ----------------------------------------------------------------------------
// sstg_pkg
// Shared types, register indexes and the quarter-wave table builder for the
// sine/square tone generator.
// ----------------------------------------------------------------------------
package sstg_pkg;

    // register indexes on the config port
    localparam logic [1:0] CFG_WAVEFORM      = 2'd0;
    localparam logic [1:0] CFG_PHASE_STEP    = 2'd1;
    localparam logic [1:0] CFG_SQUARE_PERIOD = 2'd2;
    localparam logic [1:0] CFG_AMPLITUDE     = 2'd3;

    // register reset values
    localparam logic        RST_WAVEFORM      = 1'b0;
    localparam logic [31:0] RST_PHASE_STEP    = 32'd42852281;
    localparam logic [19:0] RST_SQUARE_PERIOD = 20'd100;
    localparam logic [14:0] RST_AMPLITUDE     = 15'd0;

    // waveform codes
    localparam logic WAVE_SINE   = 1'b0;
    localparam logic WAVE_SQUARE = 1'b1;

    localparam logic [14:0] FULL_SCALE = 15'd32767;

    // controller -> datapath
    typedef struct packed {
        logic load;   // take a new burst length
        logic rd;     // table read / square decision, advance counters
        logic mul;    // scale and load the output sample register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic len_zero;  // incoming burst length is zero
        logic done;      // no samples left after the current one
    } t_dp_status;

    // Quarter-wave entry k of a 2^abits table. Only called with constant
    // arguments, so it folds to a table at elaboration.
    function automatic logic [14:0] f_quarter_entry(input longint unsigned k,
                                                    input int unsigned abits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned q;
        localparam longint unsigned ONE = 64'd1 << 30;
        x  = (64'd1686629713 * k) >> abits;
        x2 = (x * x) >> 30;
        t  = ONE - ((x2 * ONE / 64'd110) >> 30);
        t  = ONE - (((x2 / 64'd72) * t) >> 30);
        t  = ONE - (((x2 / 64'd42) * t) >> 30);
        t  = ONE - (((x2 / 64'd20) * t) >> 30);
        t  = ONE - (((x2 / 64'd6) * t) >> 30);
        t  = (x * t) >> 30;
        q  = (t * 64'd32767 + (64'd1 << 29)) >> 30;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        return q[14:0];
    endfunction

endpackage

>>> hw/rtl/sstg_ctrl.sv
// ----------------------------------------------------------------------------
// sstg_ctrl
// Sequencer for the tone generator: accepts a burst request and steps the
// datapath through read, scale and output for each sample.
// ----------------------------------------------------------------------------
module sstg_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  sstg_pkg::t_dp_status i_status,
    output sstg_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_MUL  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !i_status.len_zero) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = i_status.done ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_cmd.load  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.rd    = (r_state == S_READ);
    assign o_cmd.mul   = (r_state == S_MUL);

endmodule

>>> hw/rtl/sstg_datapath.sv
// ----------------------------------------------------------------------------
// sstg_datapath
// Config registers, phase and square counters, quarter-wave table, amplitude
// scaling and the output sample register.
// ----------------------------------------------------------------------------
module sstg_datapath #(
    parameter int SINE_TABLE_ADDR_BITS = 10,
    parameter int MAX_BURST            = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic [6:0]           i_burst_length,
    input  sstg_pkg::t_dp_cmd    i_cmd,
    output sstg_pkg::t_dp_status o_status,
    output logic [15:0]          o_sample
);

    localparam int A         = SINE_TABLE_ADDR_BITS;
    localparam int ROM_DEPTH = 2 ** A;
    localparam int REM_W     = $clog2(MAX_BURST + 1);

    // config registers
    logic        r_waveform;
    logic [31:0] r_phase_step;
    logic [19:0] r_square_period;
    logic [14:0] r_amplitude;

    // running state
    logic [31:0]      r_phase;
    logic [19:0]      r_pos;
    logic [REM_W-1:0] r_rem;

    // per-sample pipeline registers
    logic [14:0] r_rom_q;
    logic        r_sine_neg;
    logic        r_sq_neg;
    logic [15:0] r_sample;

    // quarter-wave table, folded to constants at elaboration
    logic [14:0] w_rom [0:ROM_DEPTH-1];
    for (genvar gi = 0; gi < ROM_DEPTH; gi++) begin : g_rom
        localparam logic [14:0] ENTRY = sstg_pkg::f_quarter_entry(64'(gi), A);
        assign w_rom[gi] = ENTRY;
    end

    logic [1:0]       w_quad;
    logic [A-1:0]     w_k;
    logic [A:0]       w_k_eff;
    logic [REM_W-1:0] w_len;
    logic [19:0]      w_period;
    logic [20:0]      w_pos_inc;
    logic [29:0]      w_prod;
    logic [15:0]      w_mag;
    logic [15:0]      w_amp;
    logic [15:0]      w_sine_val;
    logic [15:0]      w_sq_val;

    assign w_quad  = r_phase[31:30];
    assign w_k     = r_phase[29 -: A];
    // odd quadrants run the table backwards; index 2^A is full scale
    assign w_k_eff = w_quad[0] ? ((A+1)'(ROM_DEPTH) - {1'b0, w_k}) : {1'b0, w_k};

    assign w_len = (i_burst_length > 7'(MAX_BURST)) ? REM_W'(MAX_BURST)
                                                    : REM_W'(i_burst_length);

    assign w_period  = (r_square_period < 20'd2) ? 20'd2 : r_square_period;
    assign w_pos_inc = {1'b0, r_pos} + 21'd1;

    assign w_prod     = r_rom_q * r_amplitude;
    assign w_mag      = {1'b0, w_prod[29:15]};
    assign w_amp      = {1'b0, r_amplitude};
    assign w_sine_val = r_sine_neg ? (16'd0 - w_mag) : w_mag;
    assign w_sq_val   = r_sq_neg ? (16'd0 - w_amp) : w_amp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waveform      <= sstg_pkg::RST_WAVEFORM;
            r_phase_step    <= sstg_pkg::RST_PHASE_STEP;
            r_square_period <= sstg_pkg::RST_SQUARE_PERIOD;
            r_amplitude     <= sstg_pkg::RST_AMPLITUDE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sstg_pkg::CFG_WAVEFORM:      r_waveform      <= i_cfg_data[0];
                sstg_pkg::CFG_PHASE_STEP:    r_phase_step    <= i_cfg_data;
                sstg_pkg::CFG_SQUARE_PERIOD: r_square_period <= i_cfg_data[19:0];
                sstg_pkg::CFG_AMPLITUDE:     r_amplitude     <= i_cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_pos   <= '0;
            r_rem   <= '0;
        end else if (i_cmd.load) begin
            r_rem <= w_len;
        end else if (i_cmd.rd) begin
            r_phase <= r_phase + r_phase_step;
            r_pos   <= (w_pos_inc >= {1'b0, w_period}) ? 20'd0 : w_pos_inc[19:0];
            r_rem   <= r_rem - REM_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rom_q    <= w_k_eff[A] ? sstg_pkg::FULL_SCALE : w_rom[w_k_eff[A-1:0]];
            r_sine_neg <= w_quad[1];
            // out-of-range position also lands on the negative half
            r_sq_neg   <= !(r_pos < (w_period >> 1));
        end
        if (i_cmd.mul) begin
            r_sample <= (r_waveform == sstg_pkg::WAVE_SQUARE) ? w_sq_val : w_sine_val;
        end
    end

    assign o_status.len_zero = (i_burst_length == 7'd0);
    assign o_status.done     = (r_rem == '0);
    assign o_sample          = r_sample;

endmodule

>>> hw/rtl/sine_square_tone_generator.sv
// ----------------------------------------------------------------------------
// sine_square_tone_generator
// Burst tone generator: each request yields 0..MAX_BURST signed 16-bit samples
// of a sine (phase accumulator + quarter-wave table) or square wave.
// ----------------------------------------------------------------------------
// A request on the slave stream carries a burst length; the block answers with
// that many samples on the master stream, tlast on the final one. A length of
// zero is taken and produces nothing; lengths above MAX_BURST are clipped.
// Each sample goes through table read, amplitude multiply and output
// register, then waits while the sink holds tready low; the single
// table/multiply sequence finishes one sample before it starts the next.
// Requests are taken only between bursts. The phase accumulator and square
// position advance on every sample whatever the waveform. Config writes are
// to go in while the block is idle; the block itself does not enforce this.
//
// Registers (i_cfg_index):
//   0 waveform       bit 0: 0 = sine, 1 = square
//   1 phase_step     32-bit phase increment per sample (turn * 2^32)
//   2 square_period  20-bit period in samples (values below 2 act as 2)
//   3 amplitude      15-bit peak level
// ----------------------------------------------------------------------------
module sine_square_tone_generator #(
    parameter int SINE_TABLE_ADDR_BITS = 10,
    parameter int MAX_BURST            = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // burst requests
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [6:0] burst_length, [7] zero
    // samples
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] sample (signed)
    output logic        m_axis_tlast
);

    sstg_pkg::t_dp_cmd    w_cmd;
    sstg_pkg::t_dp_status w_status;

    sstg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    sstg_datapath #(
        .SINE_TABLE_ADDR_BITS (SINE_TABLE_ADDR_BITS),
        .MAX_BURST            (MAX_BURST)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_burst_length (s_axis_tdata[6:0]),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_sample       (m_axis_tdata)
    );

    // remaining count is already zero while the final sample is on offer
    assign m_axis_tlast = w_status.done;

endmodule
